/* design/dtep_pkg.sv */
// ----------------------------------------------------------------------------
// Date/time entry parser package
// Shared types, character codes, transition ROM and helper functions.
// ----------------------------------------------------------------------------
package dtep_pkg;

   localparam int NumStates  = 19;
   localparam int NumClasses = 17;
   localparam int QDepth     = 4;
   localparam int QAW        = $clog2(QDepth);
   localparam int QCW        = $clog2(QDepth + 1);

   // Parser states; the last three are only transit targets and never stay
   typedef enum logic [4:0] {
      PS_IDLE         = 5'd0,
      PS_DAY_TENS_LO  = 5'd1,
      PS_DAY_TENS_3   = 5'd2,
      PS_DAY_DONE     = 5'd3,
      PS_MON_TENS_1   = 5'd4,
      PS_MON_DONE     = 5'd5,
      PS_YEAR_1       = 5'd6,
      PS_YEAR_2       = 5'd7,
      PS_YEAR_3       = 5'd8,
      PS_YEAR_4       = 5'd9,
      PS_SPACE        = 5'd10,
      PS_HOUR_TENS_LO = 5'd11,
      PS_HOUR_TENS_2  = 5'd12,
      PS_HOUR_DONE    = 5'd13,
      PS_MIN_TENS     = 5'd14,
      PS_MIN_DONE     = 5'd15,
      PS_SEC_TENS     = 5'd16,
      PS_SEC_DONE     = 5'd17,
      PS_YEAR_CR      = 5'd18,
      PS_CANCEL       = 5'd19
   } parse_state_type;

   // Character classes, column index of the transition ROM
   typedef enum logic [4:0] {
      CLS_NONE  = 5'd0,
      CLS_D0    = 5'd1,
      CLS_D1    = 5'd2,
      CLS_D2    = 5'd3,
      CLS_D3    = 5'd4,
      CLS_D4    = 5'd5,
      CLS_D5    = 5'd6,
      CLS_D6    = 5'd7,
      CLS_D7    = 5'd8,
      CLS_D8    = 5'd9,
      CLS_D9    = 5'd10,
      CLS_SLASH = 5'd11,
      CLS_COLON = 5'd12,
      CLS_CR    = 5'd13,
      CLS_SPACE = 5'd14,
      CLS_BS    = 5'd15,
      CLS_ESC   = 5'd16
   } class_type;

   localparam logic [1:0] KIND_ECHO   = 2'd0;
   localparam logic [1:0] KIND_COMMIT = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;

   // One result word
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  echo_byte;
      logic [6:0]  day;
      logic [6:0]  month;
      logic [13:0] year;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic        last;
   } result_type;

   // Next state by current state and class; 19 marks a cancel
   localparam logic [4:0] NEXT_ROM [NumStates][NumClasses] = '{
      '{5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd3, 5'd3, 5'd3, 5'd3,
        5'd3, 5'd3, 5'd0, 5'd0, 5'd0, 5'd0, 5'd19, 5'd19},
      '{5'd1, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3,
        5'd3, 5'd3, 5'd3, 5'd1, 5'd1, 5'd1, 5'd19, 5'd19},
      '{5'd2, 5'd3, 5'd3, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2,
        5'd2, 5'd2, 5'd3, 5'd2, 5'd2, 5'd2, 5'd19, 5'd19},
      '{5'd3, 5'd3, 5'd4, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5,
        5'd5, 5'd5, 5'd3, 5'd3, 5'd3, 5'd3, 5'd19, 5'd19},
      '{5'd4, 5'd5, 5'd5, 5'd5, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4,
        5'd4, 5'd4, 5'd5, 5'd4, 5'd4, 5'd4, 5'd19, 5'd19},
      '{5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
        5'd6, 5'd6, 5'd5, 5'd5, 5'd5, 5'd5, 5'd19, 5'd19},
      '{5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd6, 5'd6, 5'd18, 5'd6, 5'd19, 5'd19},
      '{5'd7, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8,
        5'd8, 5'd8, 5'd7, 5'd7, 5'd18, 5'd7, 5'd19, 5'd19},
      '{5'd8, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9,
        5'd9, 5'd9, 5'd8, 5'd8, 5'd18, 5'd8, 5'd19, 5'd19},
      '{5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9,
        5'd9, 5'd9, 5'd9, 5'd9, 5'd18, 5'd10, 5'd19, 5'd19},
      '{5'd10, 5'd11, 5'd11, 5'd12, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13,
        5'd13, 5'd13, 5'd10, 5'd10, 5'd10, 5'd10, 5'd19, 5'd19},
      '{5'd11, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13,
        5'd13, 5'd13, 5'd11, 5'd13, 5'd11, 5'd11, 5'd19, 5'd19},
      '{5'd12, 5'd13, 5'd13, 5'd13, 5'd13, 5'd12, 5'd12, 5'd12, 5'd12,
        5'd12, 5'd12, 5'd12, 5'd13, 5'd12, 5'd12, 5'd19, 5'd19},
      '{5'd13, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd15, 5'd15,
        5'd15, 5'd15, 5'd13, 5'd13, 5'd13, 5'd13, 5'd19, 5'd19},
      '{5'd14, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15,
        5'd15, 5'd15, 5'd14, 5'd15, 5'd14, 5'd14, 5'd19, 5'd19},
      '{5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd17, 5'd17,
        5'd17, 5'd17, 5'd15, 5'd15, 5'd15, 5'd15, 5'd19, 5'd19},
      '{5'd16, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17,
        5'd17, 5'd17, 5'd16, 5'd16, 5'd17, 5'd16, 5'd19, 5'd19},
      '{5'd17, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
        5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
      '{5'd18, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
        5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0}
   };

   // Map a received byte to its character class
   function automatic class_type classify(input logic [7:0] b);
      class_type c;
      c = CLS_NONE;
      if (b >= CH_ZERO && b <= CH_NINE) begin
         c = class_type'(5'(b - CH_ZERO) + 5'd1);
      end else begin
         case (b)
            CH_SLASH: c = CLS_SLASH;
            CH_COLON: c = CLS_COLON;
            CH_CR:    c = CLS_CR;
            CH_SPACE: c = CLS_SPACE;
            CH_BS:    c = CLS_BS;
            CH_ESC:   c = CLS_ESC;
            default:  c = CLS_NONE;
         endcase
      end
      return c;
   endfunction

   // Times ten plus digit, wrapping to 7 bits
   function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
      return (a << 3) + (a << 1) + 7'(d);
   endfunction

   // Times ten plus digit, wrapping to 14 bits
   function automatic logic [13:0] acc14(input logic [13:0] a, input logic [3:0] d);
      return (a << 3) + (a << 1) + 14'(d);
   endfunction

   // Echo word for one character
   function automatic result_type make_echo(input logic [7:0] ch);
      result_type r;
      r           = '0;
      r.kind      = KIND_ECHO;
      r.echo_byte = ch;
      return r;
   endfunction

endpackage

/* design/date_time_entry_parser_core.sv */
// ----------------------------------------------------------------------------
// Date/time entry parser core
// Parses typed "dd/mm/yyyy hh:mm:ss" entry one received byte per word and
// reports echo characters, committed entries and cancels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per word; rsp_* carries result words:
//   echo characters, a committed entry with all six fields, or a cancel.
//   rsp_last marks the final result word caused by one byte. A byte causes
//   zero, one or two result words.
//   An accepted byte is parsed from the input register and its result words
//   are written to the output queue; rsp_* shows the queue head.
//   Throughput: one byte per cycle into the input register while req_stall is
//   low; the result side delivers one word per cycle from a four-word output
//   queue while rsp_stall is low, so bytes that cause two words drain at that rate.
//   A byte is parsed only when the queue has room for all its words; until
//   then req_stall holds it in the input register.
//   When the receiver stalls, the queue fills and then req_stall rises; the
//   payload on rsp_* holds.
//   Reset (synchronous, active high) empties the queue and input register,
//   puts the parser in idle and clears all accumulators and committed fields.
// ----------------------------------------------------------------------------
module date_time_entry_parser_core
   import dtep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_echo_byte,
   output logic [6:0]  rsp_day,
   output logic [6:0]  rsp_month,
   output logic [13:0] rsp_year,
   output logic [6:0]  rsp_hour,
   output logic [6:0]  rsp_minute,
   output logic [6:0]  rsp_second,
   output logic        rsp_last
);

   // Input register
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;

   // Parser state and accumulators
   parse_state_type state_ff, state_in;
   logic [6:0]      day_ff, day_in;
   logic [6:0]      month_ff, month_in;
   logic [13:0]     year_ff, year_in;
   logic [6:0]      hour_ff, hour_in;
   logic [6:0]      minute_ff, minute_in;
   logic [6:0]      second_ff, second_in;
   logic [6:0]      c_hour_ff, c_hour_in;
   logic [6:0]      c_minute_ff, c_minute_in;
   logic [6:0]      c_second_ff, c_second_in;

   // Output queue
   result_type      q_ff [QDepth];
   logic [QAW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]  cnt_ff, cnt_in;

   // Parse datapath
   class_type       cls;
   parse_state_type cur;
   parse_state_type nxt;
   logic            is_digit;
   logic [3:0]      digit;
   logic            changed;
   logic            do_idle;
   result_type      res_a, res_b;
   logic [1:0]      res_n;
   logic            pop;
   logic            proc;
   logic [QCW:0]    cnt_after;
   logic [4:0]      cur_idx;

   // Classify the held byte and look up the next state
   always_comb begin
      cls      = classify(in_byte_ff);
      cur_idx  = (state_ff >= 5'(NumStates)) ? 5'(PS_IDLE) : 5'(state_ff);
      cur      = parse_state_type'(cur_idx);
      nxt      = parse_state_type'(NEXT_ROM[cur_idx][cls]);
      is_digit = (in_byte_ff >= CH_ZERO) && (in_byte_ff <= CH_NINE);
      digit    = is_digit ? 4'(in_byte_ff - CH_ZERO) : 4'd0;
      changed  = (cls != CLS_NONE) && (nxt != cur);
   end

   // Run the action of the new state and build its result words
   always_comb begin
      state_in    = cur;
      day_in      = day_ff;
      month_in    = month_ff;
      year_in     = year_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      second_in   = second_ff;
      c_hour_in   = c_hour_ff;
      c_minute_in = c_minute_ff;
      c_second_in = c_second_ff;
      res_a       = '0;
      res_b       = '0;
      res_n       = 2'd0;
      do_idle     = 1'b0;
      if (changed) begin
         state_in = nxt;
         unique case (nxt)
            PS_IDLE: begin
               do_idle = 1'b1;
            end
            PS_DAY_TENS_LO, PS_DAY_TENS_3: begin
               day_in = 7'(digit);
               res_a  = make_echo(in_byte_ff);
               res_n  = 2'd1;
            end
            PS_DAY_DONE: begin
               if (in_byte_ff != CH_SLASH) begin
                  day_in = acc7(day_ff, digit);
                  res_a  = make_echo(in_byte_ff);
                  res_b  = make_echo(CH_SLASH);
                  res_n  = 2'd2;
               end else begin
                  res_a = make_echo(CH_SLASH);
                  res_n = 2'd1;
               end
            end
            PS_MON_TENS_1: begin
               month_in = 7'(digit);
               res_a    = make_echo(in_byte_ff);
               res_n    = 2'd1;
            end
            PS_MON_DONE: begin
               if (in_byte_ff != CH_SLASH) begin
                  month_in = acc7(month_ff, digit);
                  res_a    = make_echo(in_byte_ff);
                  res_b    = make_echo(CH_SLASH);
                  res_n    = 2'd2;
               end else begin
                  res_a = make_echo(CH_SLASH);
                  res_n = 2'd1;
               end
            end
            PS_YEAR_1: begin
               year_in = 14'(digit);
               res_a   = make_echo(in_byte_ff);
               res_n   = 2'd1;
            end
            PS_YEAR_2, PS_YEAR_3, PS_YEAR_4: begin
               year_in = acc14(year_ff, digit);
               res_a   = make_echo(in_byte_ff);
               res_n   = 2'd1;
            end
            PS_SPACE: begin
               hour_in   = 7'd0;
               minute_in = 7'd0;
               second_in = 7'd0;
               res_a     = make_echo(CH_SPACE);
               res_n     = 2'd1;
            end
            PS_HOUR_TENS_LO, PS_HOUR_TENS_2: begin
               hour_in = 7'(digit);
               res_a   = make_echo(in_byte_ff);
               res_n   = 2'd1;
            end
            PS_HOUR_DONE: begin
               if (in_byte_ff != CH_COLON) begin
                  hour_in = acc7(hour_ff, digit);
                  res_a   = make_echo(in_byte_ff);
                  res_b   = make_echo(CH_COLON);
                  res_n   = 2'd2;
               end else begin
                  res_a = make_echo(CH_COLON);
                  res_n = 2'd1;
               end
            end
            PS_MIN_TENS: begin
               minute_in = 7'(digit);
               res_a     = make_echo(in_byte_ff);
               res_n     = 2'd1;
            end
            PS_MIN_DONE: begin
               if (in_byte_ff != CH_COLON) begin
                  minute_in = acc7(minute_ff, digit);
                  res_a     = make_echo(in_byte_ff);
                  res_b     = make_echo(CH_COLON);
                  res_n     = 2'd2;
               end else begin
                  res_a = make_echo(CH_COLON);
                  res_n = 2'd1;
               end
            end
            PS_SEC_TENS: begin
               second_in = 7'(digit);
               res_a     = make_echo(in_byte_ff);
               res_n     = 2'd1;
            end
            PS_SEC_DONE, PS_YEAR_CR: begin
               // Take the last seconds digit if one ends the entry, then commit and report
               if (nxt == PS_SEC_DONE && is_digit) begin
                  second_in = acc7(second_ff, digit);
                  res_a     = make_echo(in_byte_ff);
                  res_n     = 2'd1;
               end
               c_hour_in   = hour_in;
               c_minute_in = minute_in;
               c_second_in = second_in;
               if (res_n == 2'd1) begin
                  res_b = '{kind: KIND_COMMIT, echo_byte: 8'd0, day: day_in,
                            month: month_in, year: year_in, hour: hour_in,
                            minute: minute_in, second: second_in, last: 1'b0};
                  res_n = 2'd2;
               end else begin
                  res_a = '{kind: KIND_COMMIT, echo_byte: 8'd0, day: day_in,
                            month: month_in, year: year_in, hour: hour_in,
                            minute: minute_in, second: second_in, last: 1'b0};
                  res_n = 2'd1;
               end
               do_idle = 1'b1;
            end
            PS_CANCEL: begin
               res_a      = '0;
               res_a.kind = KIND_CANCEL;
               res_n      = 2'd1;
               do_idle    = 1'b1;
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase
      end
      // Return to idle: clear the date, reload the time from the committed entry
      if (do_idle) begin
         state_in  = PS_IDLE;
         day_in    = 7'd0;
         month_in  = 7'd0;
         year_in   = 14'd0;
         hour_in   = c_hour_in;
         minute_in = c_minute_in;
         second_in = c_second_in;
      end
      // Mark the final word of this byte
      if (res_n == 2'd1) begin
         res_a.last = 1'b1;
      end
      if (res_n == 2'd2) begin
         res_b.last = 1'b1;
      end
   end

   // Handshake and queue bookkeeping
   always_comb begin
      pop         = rsp_valid && !rsp_stall;
      cnt_after   = (QCW+1)'(cnt_ff) - (QCW+1)'(pop) + (QCW+1)'(res_n);
      proc        = in_valid_ff && (cnt_after <= (QCW+1)'(QDepth));
      req_stall   = in_valid_ff && !proc;
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      cnt_in      = proc ? cnt_after[QCW-1:0] : (cnt_ff - QCW'(pop));
      wr_ptr_in   = proc ? (wr_ptr_ff + QAW'(res_n)) : wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff + QAW'(pop);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= PS_IDLE;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
         if (proc) begin
            state_ff <= state_in;
         end
      end
   end

   // Accumulators and committed time fields
   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff      <= '0;
         month_ff    <= '0;
         year_ff     <= '0;
         hour_ff     <= '0;
         minute_ff   <= '0;
         second_ff   <= '0;
         c_hour_ff   <= '0;
         c_minute_ff <= '0;
         c_second_ff <= '0;
      end else if (proc) begin
         day_ff      <= day_in;
         month_ff    <= month_in;
         year_ff     <= year_in;
         hour_ff     <= hour_in;
         minute_ff   <= minute_in;
         second_ff   <= second_in;
         c_hour_ff   <= c_hour_in;
         c_minute_ff <= c_minute_in;
         c_second_ff <= c_second_in;
      end
   end

   // Input byte and queue payload
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      if (proc && res_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= res_a;
      end
      if (proc && res_n == 2'd2) begin
         q_ff[wr_ptr_ff + QAW'(1)] <= res_b;
      end
   end

   // Drive the result channel from the queue head
   assign rsp_valid     = (cnt_ff != '0);
   assign rsp_kind      = q_ff[rd_ptr_ff].kind;
   assign rsp_echo_byte = q_ff[rd_ptr_ff].echo_byte;
   assign rsp_day       = q_ff[rd_ptr_ff].day;
   assign rsp_month     = q_ff[rd_ptr_ff].month;
   assign rsp_year      = q_ff[rd_ptr_ff].year;
   assign rsp_hour      = q_ff[rd_ptr_ff].hour;
   assign rsp_minute    = q_ff[rd_ptr_ff].minute;
   assign rsp_second    = q_ff[rd_ptr_ff].second;
   assign rsp_last      = q_ff[rd_ptr_ff].last;

   // Queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCW'(QDepth))
      else $error("output queue count exceeds depth");

   // Transit states never persist
   assert property (@(posedge clock) disable iff (reset)
      state_ff != PS_SEC_DONE && state_ff != PS_YEAR_CR && state_ff != PS_CANCEL)
      else $error("parser stuck in a transit state");

   // A pop with no parse drops the count by one
   assert property (@(posedge clock) disable iff (reset)
      (pop && !proc) |=> (cnt_ff == $past(cnt_ff) - QCW'(1)))
      else $error("queue count did not drop on pop");

   // Commit and cancel words are always the final word of their byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_ECHO) |-> (rsp_last && rsp_echo_byte == 8'd0))
      else $error("commit or cancel word malformed");

   // Stall only holds a byte that is waiting
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && cnt_ff != '0))
      else $error("input stalled with nothing to wait for");

endmodule
